@@ hdl/vmb_pkg.sv @@
// vmb_pkg: shared constants, beat types and fixed-point helpers for the
// look-at view matrix builder. No dependencies.
`default_nettype none
package vmb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SQ_STAGES = 32;
  localparam int DV        = FRAC_BITS + 1;
  localparam int NUM_W     = 32 + FRAC_BITS;
  localparam int NW        = FRAC_BITS + 2;
  localparam int CW        = FRAC_BITS + 4;

  localparam logic [1:0]  ROW_LAST = 2'd3;
  localparam logic [31:0] FIX_ONE  = 32'd1 << FRAC_BITS;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] d;
    logic [2:0][31:0] up;
  } side_t;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0]       sf;
    logic [2:0]       su;
    logic             zf;
    logic             zu;
  } nside_t;

  typedef struct packed {
    logic [2:0][3:0][31:0] ent;
    logic                  degen;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // drop FRAC_BITS, round half away from zero
  function automatic logic signed [63:0] scale_down(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] q;
    m = v[63] ? 64'(-v) : 64'(v);
    q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

endpackage
`default_nettype wire

@@ hdl/vmb_sqrt.sv @@
// vmb_sqrt: fully pipelined 64-bit integer square root, one result bit per stage.
// Depends on vmb_pkg.
`default_nettype none
module vmb_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad_in,
  output logic [31:0] root_out
);
  import vmb_pkg::*;

  logic [63:0] rem_r   [SQ_STAGES];
  logic [63:0] root_r  [SQ_STAGES];
  logic [63:0] vin     [SQ_STAGES];
  logic [63:0] rin     [SQ_STAGES];
  logic [63:0] rem_nxt [SQ_STAGES];
  logic [63:0] root_nxt[SQ_STAGES];

  always_comb begin
    vin[0] = rad_in;
    rin[0] = '0;
    for (int k = 1; k < SQ_STAGES; k++) begin
      vin[k] = rem_r[k-1];
      rin[k] = root_r[k-1];
    end
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (vin[k] >= rin[k] + (64'd1 << (62 - 2 * k))) begin
        rem_nxt[k]  = vin[k] - (rin[k] + (64'd1 << (62 - 2 * k)));
        root_nxt[k] = (rin[k] >> 1) + (64'd1 << (62 - 2 * k));
      end else begin
        rem_nxt[k]  = vin[k];
        root_nxt[k] = rin[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign root_out = root_r[SQ_STAGES-1][31:0];

endmodule
`default_nettype wire

@@ hdl/vmb_div.sv @@
// vmb_div: pipelined restoring divider, one quotient bit per stage.
// Depends on vmb_pkg.
`default_nettype none
module vmb_div (
  input  logic             clk,
  input  logic             en,
  input  logic [vmb_pkg::NUM_W-1:0] num_in,
  input  logic [31:0]      den_in,
  output logic [vmb_pkg::DV-1:0]    quo_out
);
  import vmb_pkg::*;

  logic [NUM_W-1:0] rem_r   [DV];
  logic [31:0]      den_r   [DV];
  logic [DV-1:0]    quo_r   [DV];
  logic [NUM_W-1:0] rin     [DV];
  logic [31:0]      din     [DV];
  logic [DV-1:0]    qin     [DV];
  logic [NUM_W-1:0] rem_nxt [DV];
  logic [DV-1:0]    quo_nxt [DV];

  always_comb begin
    rin[0] = num_in;
    din[0] = den_in;
    qin[0] = '0;
    for (int k = 1; k < DV; k++) begin
      rin[k] = rem_r[k-1];
      din[k] = den_r[k-1];
      qin[k] = quo_r[k-1];
    end
    for (int k = 0; k < DV; k++) begin
      if (rin[k] >= (NUM_W'(din[k]) << (DV - 1 - k))) begin
        rem_nxt[k] = rin[k] - (NUM_W'(din[k]) << (DV - 1 - k));
        quo_nxt[k] = {qin[k][DV-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rin[k];
        quo_nxt[k] = {qin[k][DV-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DV; k++) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= din[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo_out = quo_r[DV-1];

endmodule
`default_nettype wire

@@ hdl/vmb_serial.sv @@
// vmb_serial: holds one finished matrix and sends it as four row beats.
// Depends on vmb_pkg.
`default_nettype none
module vmb_serial (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  vmb_pkg::item_t       item_in,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_row_number,
  output logic signed [31:0]   out_col0,
  output logic signed [31:0]   out_col1,
  output logic signed [31:0]   out_col2,
  output logic signed [31:0]   out_col3,
  output logic                 out_degenerate,
  output logic                 out_last_row
);
  import vmb_pkg::*;

  logic       busy_r;
  logic [1:0] row_r;
  item_t      item_r;

  assign free = !busy_r || (!out_stall && row_r == ROW_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      row_r  <= '0;
    end else if (busy_r && !out_stall) begin
      if (row_r == ROW_LAST) begin
        busy_r <= 1'b0;
      end else begin
        row_r <= row_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  always_comb begin
    case (row_r)
      2'd0, 2'd1, 2'd2: begin
        out_col0 = item_r.ent[row_r][0];
        out_col1 = item_r.ent[row_r][1];
        out_col2 = item_r.ent[row_r][2];
        out_col3 = item_r.ent[row_r][3];
      end
      default: begin
        out_col0 = '0;
        out_col1 = '0;
        out_col2 = '0;
        out_col3 = FIX_ONE;
      end
    endcase
  end

  assign out_valid      = busy_r;
  assign out_row_number = row_r;
  assign out_degenerate = item_r.degen;
  assign out_last_row   = (row_r == ROW_LAST);

endmodule
`default_nettype wire

@@ hdl/view_matrix_builder_unit.sv @@
// view_matrix_builder_unit: look-at view matrix in signed Q16.16, pipelined.
// Each item leaves as four row beats; the pipeline accepts a beat every cycle
// unless a finished matrix is waiting.
// Reset: synchronous active-low rst_n clears valid bits and the row sequencer.
// Depends on vmb_pkg, vmb_sqrt, vmb_div, vmb_serial.
`default_nettype none
module view_matrix_builder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_eye_x,
  input  logic signed [31:0] in_eye_y,
  input  logic signed [31:0] in_eye_z,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_z,
  input  logic signed [31:0] in_upvec_x,
  input  logic signed [31:0] in_upvec_y,
  input  logic signed [31:0] in_upvec_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row_number,
  output logic signed [31:0] out_col0,
  output logic signed [31:0] out_col1,
  output logic signed [31:0] out_col2,
  output logic signed [31:0] out_col3,
  output logic               out_degenerate,
  output logic               out_last_row
);
  import vmb_pkg::*;

  localparam int LAT = 45 + DV;

  logic en;
  logic free;
  logic load;
  logic vld_r [LAT];

  logic signed [31:0] eye1_r [3];
  logic signed [31:0] tgt1_r [3];
  logic signed [31:0] upv1_r [3];
  side_t              side2_r;
  side_t              side3_r;
  logic [63:0]        sqf3_r [3];
  logic [63:0]        squ3_r [3];
  side_t              side4_r;
  logic [63:0]        sf4_r;
  logic [63:0]        su4_r;
  logic [31:0]        lf;
  logic [31:0]        lu;
  side_t              sideq_r [SQ_STAGES];
  logic [31:0]        magf [3];
  logic [31:0]        magu [3];
  logic [NUM_W-1:0]   numf_r [3];
  logic [NUM_W-1:0]   numu_r [3];
  logic [31:0]        lf_r;
  logic [31:0]        lu_r;
  nside_t             nside_r;
  nside_t             divq_r [DV];
  logic [DV-1:0]      qf [3];
  logic [DV-1:0]      qu [3];
  logic signed [NW-1:0]    fwd7_r [3];
  logic signed [NW-1:0]    un7_r [3];
  logic signed [31:0]      eye7_r [3];
  logic                    dg7_r;
  logic signed [2*NW-1:0]  p1_r [6];
  logic signed [NW-1:0]    fwd8_r [3];
  logic signed [31:0]      eye8_r [3];
  logic                    dg8_r;
  logic signed [CW-1:0]    left9_r [3];
  logic signed [NW-1:0]    fwd9_r [3];
  logic signed [31:0]      eye9_r [3];
  logic                    dg9_r;
  logic signed [CW+NW-1:0] p2_r [6];
  logic signed [CW-1:0]    left10_r [3];
  logic signed [NW-1:0]    fwd10_r [3];
  logic signed [31:0]      eye10_r [3];
  logic                    dg10_r;
  logic signed [CW-1:0]    tup11_r [3];
  logic signed [CW-1:0]    left11_r [3];
  logic signed [NW-1:0]    fwd11_r [3];
  logic signed [31:0]      eye11_r [3];
  logic                    dg11_r;
  logic signed [CW-1:0]    row11 [3][3];
  logic signed [CW-1:0]    ent12_r [3][3];
  logic signed [CW+31:0]   pe12_r [3][3];
  logic                    dg12_r;
  logic signed [CW-1:0]    ent13_r [3][3];
  logic signed [63:0]      acc13_r [3];
  logic                    dg13_r;
  logic signed [CW-1:0]    ent14_r [3][3];
  logic signed [31:0]      col3_14_r [3];
  logic                    dg14_r;
  item_t                   item;

  // only a finished matrix that cannot hand off holds the pipeline
  assign en       = free || !vld_r[LAT-1];
  assign in_stall = !en;
  assign load     = en && vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // front: capture, difference, squares, sums
  always_ff @(posedge clk) begin
    if (en) begin
      eye1_r[0] <= in_eye_x;    eye1_r[1] <= in_eye_y;    eye1_r[2] <= in_eye_z;
      tgt1_r[0] <= in_target_x; tgt1_r[1] <= in_target_y; tgt1_r[2] <= in_target_z;
      upv1_r[0] <= in_upvec_x;  upv1_r[1] <= in_upvec_y;  upv1_r[2] <= in_upvec_z;
      for (int i = 0; i < 3; i++) begin
        side2_r.eye[i] <= eye1_r[i];
        side2_r.d[i]   <= sat32(64'(tgt1_r[i]) - 64'(eye1_r[i]));
        side2_r.up[i]  <= upv1_r[i];
        sqf3_r[i] <= 64'($signed(64'($signed(side2_r.d[i]))) *
                         $signed(64'($signed(side2_r.d[i]))));
        squ3_r[i] <= 64'($signed(64'($signed(side2_r.up[i]))) *
                         $signed(64'($signed(side2_r.up[i]))));
      end
      side3_r <= side2_r;
      side4_r <= side3_r;
      sf4_r   <= sqf3_r[0] + sqf3_r[1] + sqf3_r[2];
      su4_r   <= squ3_r[0] + squ3_r[1] + squ3_r[2];
    end
  end

  vmb_sqrt u_sqrt_f (.clk(clk), .en(en), .rad_in(sf4_r), .root_out(lf));
  vmb_sqrt u_sqrt_u (.clk(clk), .en(en), .rad_in(su4_r), .root_out(lu));

  always_ff @(posedge clk) begin
    if (en) begin
      sideq_r[0] <= side4_r;
      for (int i = 1; i < SQ_STAGES; i++) sideq_r[i] <= sideq_r[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      magf[i] = sideq_r[SQ_STAGES-1].d[i][31] ?
                32'(-$signed(sideq_r[SQ_STAGES-1].d[i])) : sideq_r[SQ_STAGES-1].d[i];
      magu[i] = sideq_r[SQ_STAGES-1].up[i][31] ?
                32'(-$signed(sideq_r[SQ_STAGES-1].up[i])) : sideq_r[SQ_STAGES-1].up[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        numf_r[i]      <= (NUM_W'(magf[i]) << FRAC_BITS) + NUM_W'(lf >> 1);
        numu_r[i]      <= (NUM_W'(magu[i]) << FRAC_BITS) + NUM_W'(lu >> 1);
        nside_r.eye[i] <= sideq_r[SQ_STAGES-1].eye[i];
        nside_r.sf[i]  <= sideq_r[SQ_STAGES-1].d[i][31];
        nside_r.su[i]  <= sideq_r[SQ_STAGES-1].up[i][31];
      end
      lf_r       <= lf;
      lu_r       <= lu;
      nside_r.zf <= (lf == '0);
      nside_r.zu <= (lu == '0);
      divq_r[0]  <= nside_r;
      for (int i = 1; i < DV; i++) divq_r[i] <= divq_r[i-1];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    vmb_div u_div_f (.clk(clk), .en(en), .num_in(numf_r[g]), .den_in(lf_r), .quo_out(qf[g]));
    vmb_div u_div_u (.clk(clk), .en(en), .num_in(numu_r[g]), .den_in(lu_r), .quo_out(qu[g]));
  end

  // sign, two cross products, translation dot products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        fwd7_r[i] <= divq_r[DV-1].zf ? '0 :
                     (divq_r[DV-1].sf[i] ? -NW'(qf[i]) : NW'(qf[i]));
        un7_r[i]  <= divq_r[DV-1].zu ? '0 :
                     (divq_r[DV-1].su[i] ? -NW'(qu[i]) : NW'(qu[i]));
        eye7_r[i] <= $signed(divq_r[DV-1].eye[i]);
      end
      dg7_r <= divq_r[DV-1].zf || divq_r[DV-1].zu;

      p1_r[0] <= fwd7_r[1] * un7_r[2];
      p1_r[1] <= fwd7_r[2] * un7_r[1];
      p1_r[2] <= fwd7_r[2] * un7_r[0];
      p1_r[3] <= fwd7_r[0] * un7_r[2];
      p1_r[4] <= fwd7_r[0] * un7_r[1];
      p1_r[5] <= fwd7_r[1] * un7_r[0];
      fwd8_r <= fwd7_r;
      eye8_r <= eye7_r;
      dg8_r  <= dg7_r;

      for (int i = 0; i < 3; i++) begin
        left9_r[i] <= CW'(scale_down(64'(p1_r[2*i]) - 64'(p1_r[2*i+1])));
      end
      fwd9_r <= fwd8_r;
      eye9_r <= eye8_r;
      dg9_r  <= dg8_r;

      p2_r[0] <= left9_r[1] * fwd9_r[2];
      p2_r[1] <= left9_r[2] * fwd9_r[1];
      p2_r[2] <= left9_r[2] * fwd9_r[0];
      p2_r[3] <= left9_r[0] * fwd9_r[2];
      p2_r[4] <= left9_r[0] * fwd9_r[1];
      p2_r[5] <= left9_r[1] * fwd9_r[0];
      left10_r <= left9_r;
      fwd10_r  <= fwd9_r;
      eye10_r  <= eye9_r;
      dg10_r   <= dg9_r;

      for (int i = 0; i < 3; i++) begin
        tup11_r[i] <= CW'(scale_down(64'(p2_r[2*i]) - 64'(p2_r[2*i+1])));
      end
      left11_r <= left10_r;
      fwd11_r  <= fwd10_r;
      eye11_r  <= eye10_r;
      dg11_r   <= dg10_r;

      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          ent12_r[r][i] <= row11[r][i];
          pe12_r[r][i]  <= row11[r][i] * eye11_r[i];
        end
      end
      dg12_r <= dg11_r;

      for (int r = 0; r < 3; r++) begin
        acc13_r[r] <= 64'(pe12_r[r][0]) + 64'(pe12_r[r][1]) + 64'(pe12_r[r][2]);
      end
      ent13_r <= ent12_r;
      dg13_r  <= dg12_r;

      for (int r = 0; r < 3; r++) begin
        col3_14_r[r] <= sat32(-scale_down(acc13_r[r]));
      end
      ent14_r <= ent13_r;
      dg14_r  <= dg13_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row11[0][i] = left11_r[i];
      row11[1][i] = tup11_r[i];
      row11[2][i] = -CW'(fwd11_r[i]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 3; i++) item.ent[r][i] = 32'(ent14_r[r][i]);
      item.ent[r][3] = col3_14_r[r];
    end
    item.degen = dg14_r;
  end

  vmb_serial u_serial (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .item_in        (item),
    .free           (free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_number (out_row_number),
    .out_col0       (out_col0),
    .out_col1       (out_col1),
    .out_col2       (out_col2),
    .out_col3       (out_col3),
    .out_degenerate (out_degenerate),
    .out_last_row   (out_last_row)
  );

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_row_number != ROW_LAST |=>
    out_valid && out_row_number == $past(out_row_number) + 2'd1)
    else $error("row beats out of order");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_number == ROW_LAST)))
    else $error("last_row flag mismatch");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] && out_valid && out_stall |-> in_stall)
    else $error("pipeline advanced while final row stalled");

  a_degen_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_row_number != ROW_LAST |=> $stable(out_degenerate))
    else $error("degenerate changed within a matrix");

endmodule
`default_nettype wire

@@ tb/view_matrix_builder_unit_test.sv @@
// Self-checking bench for view_matrix_builder_unit: random-gap driver and
// monitor, in-bench look-at matrix predictor compared row by row. Needs vmb_pkg.
`default_nettype none
module view_matrix_builder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vmb_pkg::*;

  typedef struct {
    logic signed [31:0] v[9];
  } cam_t;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] c[4];
    logic        degen;
    logic        last;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_f[9];
  logic out_valid, out_stall = 1'b0;
  logic [1:0] out_row_number;
  logic signed [31:0] out_col0, out_col1, out_col2, out_col3;
  logic out_degenerate, out_last_row;

  cam_t pending_cams[$];
  row_t expected_rows[$];
  int errors = 0;
  int cycle = 0;
  int gap = 0;
  int ostall = 0;
  bit stim_done = 0;
  bit hold_off = 0;

  initial for (int i = 0; i < 9; i++) in_f[i] = '0;

  view_matrix_builder_unit dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_eye_x(in_f[0]), .in_eye_y(in_f[1]), .in_eye_z(in_f[2]),
    .in_target_x(in_f[3]), .in_target_y(in_f[4]), .in_target_z(in_f[5]),
    .in_upvec_x(in_f[6]), .in_upvec_y(in_f[7]), .in_upvec_z(in_f[8]),
    .out_valid, .out_stall, .out_row_number,
    .out_col0, .out_col1, .out_col2, .out_col3,
    .out_degenerate, .out_last_row
  );

  always #1 clk = ~clk;

  function automatic longint sat_w(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_q(longint v);
    longint unsigned m, q;
    m = v < 0 ? -v : v;
    q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_vec(longint d[3], output longint n[3]);
    longint unsigned s, len, m, q;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(d[i] * d[i]);
    len = root64(s);
    for (int i = 0; i < 3; i++) n[i] = 0;
    if (len == 0) return 0;
    for (int i = 0; i < 3; i++) begin
      m = d[i] < 0 ? -d[i] : d[i];
      q = ((m << FRAC_BITS) + (len >> 1)) / len;
      n[i] = d[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic void cross_q(longint a[3], longint b[3], output longint r[3]);
    r[0] = round_q(a[1] * b[2] - a[2] * b[1]);
    r[1] = round_q(a[2] * b[0] - a[0] * b[2]);
    r[2] = round_q(a[0] * b[1] - a[1] * b[0]);
  endfunction

  task automatic predict_view(cam_t c);
    longint eye[3], d[3], up[3], fwd[3], un[3], lft[3], tup[3], m[4][4], acc;
    bit okf, oku;
    row_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = c.v[i];
      d[i] = sat_w(longint'(c.v[3 + i]) - eye[i]);
      up[i] = c.v[6 + i];
    end
    okf = unit_vec(d, fwd);
    oku = unit_vec(up, un);
    cross_q(fwd, un, lft);
    cross_q(lft, fwd, tup);
    for (int i = 0; i < 3; i++) begin
      m[0][i] = lft[i];
      m[1][i] = tup[i];
      m[2][i] = -fwd[i];
      m[3][i] = 0;
    end
    for (int k = 0; k < 3; k++) begin
      acc = m[k][0] * eye[0] + m[k][1] * eye[1] + m[k][2] * eye[2];
      m[k][3] = sat_w(-round_q(acc));
    end
    m[3][3] = longint'(1) << FRAC_BITS;
    for (int k = 0; k < 4; k++) begin
      r.row = 2'(k);
      for (int i = 0; i < 4; i++) r.c[i] = m[k][i][31:0];
      r.degen = !(okf && oku);
      r.last = (k == 3);
      expected_rows.push_back(r);
    end
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
    end else if (gap > 0 || hold_off) begin
      if (gap > 0) gap <= gap - 1;
      in_valid <= 1'b0;
    end else if (pending_cams.size() != 0) begin
      cam_t c;
      c = pending_cams.pop_front();
      predict_view(c);
      for (int i = 0; i < 9; i++) in_f[i] <= c.v[i];
      in_valid <= 1'b1;
      gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
      stim_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        row_t e;
        if (expected_rows.size() == 0) begin
          $error("unexpected row beat %0d", out_row_number);
          errors++;
        end else begin
          e = expected_rows.pop_front();
          if (out_row_number !== e.row) begin
            $error("row_number exp %0d got %0d", e.row, out_row_number); errors++;
          end
          if (out_col0 !== e.c[0]) begin
            $error("col0 exp %h got %h", e.c[0], out_col0); errors++;
          end
          if (out_col1 !== e.c[1]) begin
            $error("col1 exp %h got %h", e.c[1], out_col1); errors++;
          end
          if (out_col2 !== e.c[2]) begin
            $error("col2 exp %h got %h", e.c[2], out_col2); errors++;
          end
          if (out_col3 !== e.c[3]) begin
            $error("col3 exp %h got %h", e.c[3], out_col3); errors++;
          end
          if (out_degenerate !== e.degen) begin
            $error("degenerate exp %0d got %0d", e.degen, out_degenerate); errors++;
          end
          if (out_last_row !== e.last) begin
            $error("last_row exp %0d got %0d", e.last, out_last_row); errors++;
          end
        end
      end
      if (ostall > 0) begin
        ostall <= ostall - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        ostall <= pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_cam(logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    cam_t c;
    c.v = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    pending_cams.push_back(c);
  endtask

  initial begin
    cam_t c;
    localparam logic [31:0] ONE = 32'h10000;
    localparam logic [31:0] MX = 32'h7fffffff;
    localparam logic [31:0] MN = 32'h80000000;
    add_cam(0, 0, 0, 0, 0, -ONE, 0, ONE, 0);
    add_cam(ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 0, ONE, 0);
    add_cam(ONE, 0, 0, 0, ONE, 0, 0, 0, 0);
    add_cam(5, 5, 5, 5, 5, 5, 0, 0, 0);
    add_cam(MN, MN, MN, MX, MX, MX, MX, MX, MX);
    add_cam(MX, MX, MX, MN, MN, MN, MN, MN, MN);
    add_cam(MX, MN, MX, MN, MX, MN, MN, MX, 1);
    add_cam(MX, MX, MX, 0, 0, 0, 1, 0, 0);
    add_cam(MN, 0, MX, 0, MX, MN, 0, 0, 32'hffffffff);
    add_cam(0, 0, 0, 1, 0, 0, 0, 1, 0);
    add_cam(0, 0, 0, 0, 0, ONE, 0, 0, ONE);
    add_cam(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, MX, 0, MN);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < 118; k++) begin
      for (int i = 0; i < 9; i++) c.v[i] = rnd_word();
      if ($urandom_range(0, 19) == 0) c.v[3:5] = c.v[0:2];
      if ($urandom_range(0, 19) == 0) c.v[6:8] = '{0, 0, 0};
      pending_cams.push_back(c);
    end
    wait (pending_cams.size() < 60);
    hold_off = 1;
    wait (expected_rows.size() == 0);
    hold_off = 0;
  end

  initial begin
    wait (stim_done && expected_rows.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    wait (cycle >= 200000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
